>>> rtl/assert_macros.svh
// Assertion macros for the sliding window median RTL.
// Plain text header, no dependencies; included by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while rst is high.
`define SWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check, also evaluated during reset.
`define SWM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/swm_pkg.sv
// Shared constants, types and helpers for the sliding window median.
// No dependencies; used by swm_cell, swm_readout and sliding_window_median.
package swm_pkg;

  localparam int WINDOW_MAX   = 64;
  localparam int SAMPLE_WIDTH = 16;
  localparam int IDX_W        = $clog2(WINDOW_MAX);
  localparam int CNT_W        = $clog2(WINDOW_MAX + 1);
  localparam int OUT_W        = SAMPLE_WIDTH + 1;
  localparam int CFG_W        = 7;
  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(3);

  // What every cell sees from the controller.
  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic signed [SAMPLE_WIDTH-1:0] old_val;
    logic                           remove;
    logic                           load;
  } bcast_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] val;
    logic [IDX_W-1:0]               age;
    logic                           ge_o;   // at or past the removal slot
    logic                           gt_s;   // greater than the new sample
  } link_t;

  localparam link_t LEFT_END  = '{val: '0, age: '0, ge_o: 1'b0, gt_s: 1'b0};
  localparam link_t RIGHT_END = '{val: '0, age: '0, ge_o: 1'b1, gt_s: 1'b1};

  // Clamp the register to 1..WINDOW_MAX.
  function automatic logic [CNT_W-1:0] eff_window(input logic [CFG_W-1:0] ws);
    logic [CNT_W-1:0] k;
    begin
      if (ws == '0) begin
        k = CNT_W'(1);
      end else if (CNT_W'(ws) > CNT_W'(WINDOW_MAX)) begin
        k = CNT_W'(WINDOW_MAX);
      end else begin
        k = CNT_W'(ws);
      end
      return k;
    end
  endfunction

endpackage

>>> rtl/swm_cell.sv
// One slot of the sorted window: value plus age, shifts with neighbors.
// Depends on swm_pkg (bcast_t, link_t).
module swm_cell (
  input  logic           clk,
  input  swm_pkg::bcast_t bc,
  input  logic           vld,
  input  swm_pkg::link_t left,
  input  swm_pkg::link_t right,
  output swm_pkg::link_t me
);

  logic signed [swm_pkg::SAMPLE_WIDTH-1:0] val, val_next;
  logic [swm_pkg::IDX_W-1:0]               age, age_next;
  logic                                    is_r, past_r, right_past;

  always_comb begin
    me.val  = val;
    me.age  = age;
    me.gt_s = !vld || (val > bc.sample);
    me.ge_o = bc.remove && (!vld || (val >= bc.old_val));
    // first slot at or above the oldest value is the one that leaves
    is_r       = me.ge_o && !left.ge_o;
    past_r     = me.ge_o && left.ge_o;
    right_past = right.ge_o && me.ge_o;
    if (right_past && !right.gt_s) begin
      val_next = right.val;
      age_next = right.age + 1'b1;
    end else if (!is_r && (past_r == me.gt_s)) begin
      val_next = val;
      age_next = age + 1'b1;
    end else if (!left.ge_o && left.gt_s) begin
      val_next = left.val;
      age_next = left.age + 1'b1;
    end else begin
      val_next = bc.sample;
      age_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (bc.load) begin
      val <= val_next;
      age <= age_next;
    end
  end

endmodule

>>> rtl/swm_readout.sv
// Reads the cell row: doubled median and the value of the oldest sample.
// Depends on swm_pkg (link_t, widths).
module swm_readout (
  input  swm_pkg::link_t                         row [swm_pkg::WINDOW_MAX],
  input  logic [swm_pkg::WINDOW_MAX-1:0]         vld,
  input  logic [swm_pkg::CNT_W-1:0]              k,
  output logic signed [swm_pkg::OUT_W-1:0]       median,
  output logic signed [swm_pkg::SAMPLE_WIDTH-1:0] oldest
);

  logic [swm_pkg::IDX_W-1:0]               half, lo_idx, k_m1;
  logic signed [swm_pkg::SAMPLE_WIDTH-1:0] lo_val, hi_val;
  logic [swm_pkg::SAMPLE_WIDTH-1:0]        acc;

  always_comb begin
    half   = k[swm_pkg::IDX_W:1];
    lo_idx = k[0] ? half : half - 1'b1;
    lo_val = row[lo_idx].val;
    hi_val = row[half].val;
    median = swm_pkg::OUT_W'(lo_val) + swm_pkg::OUT_W'(hi_val);
  end

  // one-hot select of the slot whose age is k-1
  always_comb begin
    k_m1 = swm_pkg::IDX_W'(k - 1'b1);
    acc  = '0;
    for (int i = 0; i < swm_pkg::WINDOW_MAX; i++) begin
      if (vld[i] && (row[i].age == k_m1)) begin
        acc = acc | row[i].val;
      end
    end
    oldest = acc;
  end

endmodule

>>> rtl/sliding_window_median.sv
// Top level of the sliding window median filter: control, cell row, output register.
// Depends on swm_pkg, swm_cell, swm_readout and assert_macros.svh.
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------
//  in      | in_valid / in_stall     | sample[15:0], end_of_sequence
//  out     | out_valid / out_stall   | median_doubled[16:0]
//  cfg     | cfg_wr_en               | cfg_wr_data[6:0] (window_size)
//
// Steps: the cell row first inserts the sample (and drops the oldest one when the
//   window is full), then the median is read out of the row into the output register.
// The next item is taken once the result of the previous one sits in the output
//   register (or once it is known to give none), so the block takes one item at a time.
// Reset (rst, synchronous): window_size 3, window empty, no result pending, input stalled.
// A stalled output holds the readout cycle and so holds the input side.
`include "assert_macros.svh"

module sliding_window_median (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_wr_en,
  input  logic [swm_pkg::CFG_W-1:0]               cfg_wr_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [swm_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic                                    end_of_sequence,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [swm_pkg::OUT_W-1:0]        median_doubled
);

  // control registers
  logic [swm_pkg::CFG_W-1:0]               window_size;
  logic [swm_pkg::CNT_W-1:0]               fill, fill_next;
  logic                                    pend, produce_q;
  logic signed [swm_pkg::SAMPLE_WIDTH-1:0] old_val;

  logic [swm_pkg::CNT_W-1:0]               k;
  logic                                    accept, load_out, produce;
  logic [swm_pkg::WINDOW_MAX-1:0]          vld;
  swm_pkg::bcast_t                         bc;
  swm_pkg::link_t                          links [swm_pkg::WINDOW_MAX];
  logic signed [swm_pkg::OUT_W-1:0]        median;
  logic signed [swm_pkg::SAMPLE_WIDTH-1:0] oldest;

  assign k        = swm_pkg::eff_window(window_size);
  assign in_stall = pend || rst;
  assign accept   = in_valid && !in_stall;
  // readout cycle may load the output register unless it is full and stalled
  assign load_out = pend && produce_q && !(out_valid && out_stall);

  // full window: the incoming item pushes the oldest one out; end_of_sequence empties it
  always_comb begin
    bc.sample  = sample;
    bc.old_val = old_val;
    bc.remove  = (fill == k);
    bc.load    = accept;
    produce    = (fill == k) || ((fill + 1'b1) == k);
    if (end_of_sequence) begin
      fill_next = '0;
    end else if (fill == k) begin
      fill_next = fill;
    end else begin
      fill_next = fill + 1'b1;
    end
  end

  // the sorted row; each slot trades with its two neighbors
  for (genvar i = 0; i < swm_pkg::WINDOW_MAX; i++) begin : g_cell
    swm_pkg::link_t lft, rgt;
    assign vld[i] = (swm_pkg::CNT_W'(i) < fill);
    if (i == 0) begin : g_first
      assign lft = swm_pkg::LEFT_END;
    end else begin : g_left
      assign lft = links[i-1];
    end
    if (i == swm_pkg::WINDOW_MAX - 1) begin : g_last
      assign rgt = swm_pkg::RIGHT_END;
    end else begin : g_right
      assign rgt = links[i+1];
    end
    swm_cell u_cell (
      .clk   (clk),
      .bc    (bc),
      .vld   (vld[i]),
      .left  (lft),
      .right (rgt),
      .me    (links[i])
    );
  end

  swm_readout u_readout (
    .row    (links),
    .vld    (vld),
    .k      (k),
    .median (median),
    .oldest (oldest)
  );

  // oldest value is re-read every cycle; the row never changes in back-to-back cycles
  always_ff @(posedge clk) begin
    old_val <= oldest;
    if (load_out) begin
      median_doubled <= median;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swm_pkg::WINDOW_RESET;
      fill        <= '0;
      pend        <= 1'b0;
      produce_q   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_size <= cfg_wr_data;
        fill        <= '0;
      end else if (accept) begin
        fill <= fill_next;
      end
      if (accept) begin
        pend      <= 1'b1;
        produce_q <= produce;
      end else if (pend && (!produce_q || load_out)) begin
        pend <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SWM_ASSERT(a_fill_bound, fill <= k, "fill count above window size")
  `SWM_ASSERT(a_one_at_a_time, accept |=> pend && in_stall, "item taken during readout")
  `SWM_ASSERT(a_eos_clears, (accept && end_of_sequence) |=> fill == '0, "window not cleared")
  `SWM_ASSERT(a_no_result_drop, (pend && !produce_q) |=> !pend, "empty readout stuck")

endmodule

>>> tb/swm_median_checker.sv
// Checker for sliding_window_median: predicts every median from the accepted items
// and compares it with what leaves the output channel. Depends on swm_pkg only.
module swm_median_checker
  import swm_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [CFG_W-1:0]               cfg_wr_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           end_of_sequence,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic signed [OUT_W-1:0]        median_doubled,
  output int                             pending_medians,
  output int                             mismatch_count
);

  logic signed [SAMPLE_WIDTH-1:0] arrivals [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] ordered  [WINDOW_MAX];
  int                             oldest;
  int                             held;
  logic [CFG_W-1:0]               win_reg;
  logic signed [OUT_W-1:0]        median_queue [$];
  int                             errs;

  function automatic int window_span();
    int k;
    k = int'(win_reg);
    if (k < 1) k = 1;
    if (k > WINDOW_MAX) k = WINDOW_MAX;
    return k;
  endfunction

  task automatic ordered_insert(input int cnt, input logic signed [SAMPLE_WIDTH-1:0] v);
    int pos;
    pos = 0;
    while (pos < cnt && ordered[pos] <= v) pos++;
    for (int i = cnt; i > pos; i--) ordered[i] = ordered[i-1];
    ordered[pos] = v;
  endtask

  // drops exactly one entry equal to v
  task automatic ordered_remove(input int cnt, input logic signed [SAMPLE_WIDTH-1:0] v);
    int i;
    i = 0;
    while (i < cnt && ordered[i] != v) i++;
    while (i + 1 < cnt) begin
      ordered[i] = ordered[i+1];
      i++;
    end
  endtask

  task automatic predict_median(input logic signed [SAMPLE_WIDTH-1:0] s, input logic eos);
    int k;
    logic signed [SAMPLE_WIDTH-1:0] gone;
    logic signed [OUT_W-1:0] lo, hi;
    k = window_span();
    if (held > k) begin
      held = 0;
      oldest = 0;
    end
    if (held < k) begin
      arrivals[(oldest + held) % WINDOW_MAX] = s;
      ordered_insert(held, s);
      held++;
    end else begin
      gone = arrivals[oldest];
      ordered_remove(held, gone);
      ordered_insert(held - 1, s);
      arrivals[(oldest + k) % WINDOW_MAX] = s;
      oldest = (oldest + 1) % WINDOW_MAX;
    end
    if (held == k) begin
      hi = ordered[k / 2];
      lo = (k % 2 == 1) ? hi : ordered[k / 2 - 1];
      median_queue.insert(median_queue.size(), lo + hi);
    end
    if (eos) begin
      held = 0;
      oldest = 0;
    end
  endtask

  always @(posedge clk) begin
    logic signed [OUT_W-1:0] want;
    if (rst) begin
      win_reg = WINDOW_RESET;
      oldest = 0;
      held = 0;
      median_queue.delete();
    end else begin
      // results leave before this edge's item can add one
      if (out_valid && !out_stall) begin
        if (median_queue.size() == 0) begin
          $display("%0t: median_doubled expected none, actual %0d", $time, median_doubled);
          errs++;
        end else begin
          want = median_queue.pop_front();
          if (median_doubled !== want) begin
            $display("%0t: median_doubled expected %0d, actual %0d",
                     $time, want, median_doubled);
            errs++;
          end
        end
      end
      if (cfg_wr_en) begin
        win_reg = cfg_wr_data;
        oldest = 0;
        held = 0;
      end
      if (in_valid && !in_stall) predict_median(sample, end_of_sequence);
    end
    pending_medians <= median_queue.size();
    mismatch_count  <= errs;
  end

endmodule

>>> tb/tb_sliding_window_median.sv
// Testbench top for sliding_window_median: clock, reset, stimulus, receiver stalls,
// watchdog and verdict. Depends on swm_pkg, the block and swm_median_checker.
module tb_sliding_window_median;
  import swm_pkg::*;

  // Cycles with no item moved on either side before the run is called hung.
  // Longest legal quiet stretch is the receiver hold-off below.
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_wr_en;
  logic [CFG_W-1:0]               cfg_wr_data;
  logic                           in_valid;
  logic                           in_stall;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           end_of_sequence;
  logic                           out_valid;
  logic                           out_stall;
  logic signed [OUT_W-1:0]        median_doubled;

  int   pending_medians;
  int   mismatch_count;
  int   idle_cycles;
  bit   no_gaps;        // sender runs back to back in this phase
  logic hold_req;       // asks the receiver for one long hold-off
  bit   hold_done;

  // window 3 from reset: extremes, end before fill, duplicates, min and max medians
  logic signed [SAMPLE_WIDTH-1:0] odd_s [18] = '{
    16'sh7fff, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh7fff, 16'sh7fff, 16'sh7fff,
    16'sd5, 16'sd5,
    16'sd7, 16'sd7, 16'sd3, 16'sd7, 16'sd3, 16'sd3,
    -16'sh8000, -16'sh8000, -16'sh8000};
  bit odd_e [18] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
                     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
  // window 2: even medians at both ends and across zero
  logic signed [SAMPLE_WIDTH-1:0] even_s [5] = '{
    16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000, -16'sh0001};
  bit even_e [5] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
  // window plan: unit, widest, zero (acts as 1), saturating, then assorted
  int plan_win [10] = '{1, 64, 0, 127, 2, 4, 7, 3, 5, 2};
  int plan_cnt [10] = '{80, 200, 60, 140, 100, 90, 90, 60, 60, 60};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sliding_window_median dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .sample          (sample),
    .end_of_sequence (end_of_sequence),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .median_doubled  (median_doubled)
  );

  swm_median_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .sample          (sample),
    .end_of_sequence (end_of_sequence),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .median_doubled  (median_doubled),
    .pending_medians (pending_medians),
    .mismatch_count  (mismatch_count)
  );

  // Watchdog: any accepted item or register write counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: mostly ready, short and occasional long stalls, quiet stretches,
  // and once a long hold-off so the block backs up into its input.
  initial begin : receiver
    int r;
    int len;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          // stretch with no stalls at all
          out_stall <= 1'b0;
          repeat (40) @(posedge clk);
        end else begin
          if (r < 70) len = 0;
          else if (r < 94) len = $urandom_range(1, 3);
          else len = $urandom_range(8, 30);
          if (len > 0) begin
            out_stall <= 1'b1;
            repeat (len) @(posedge clk);
          end
          out_stall <= 1'b0;
        end
      end
    end
  end

  function automatic int next_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mix of full-range values, tight clusters for duplicates, extremes.
  function automatic logic signed [SAMPLE_WIDTH-1:0] draw_sample();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      v = int'($urandom_range(0, 65535));
    end else if (r < 65) begin
      v = int'($urandom_range(0, 7)) - 4;
    end else if (r < 75) begin
      case ($urandom_range(0, 3))
        0: v = 32767;
        1: v = -32768;
        2: v = 0;
        default: v = -1;
      endcase
    end else begin
      v = int'($urandom_range(0, 600)) - 300;
    end
    return SAMPLE_WIDTH'(v);
  endfunction

  // Sequence length: mostly long enough to fill the window and slide,
  // sometimes cut short so the end-of-sequence lands before it fills.
  function automatic int seq_len(input int k);
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, k);
    return k + $urandom_range(0, 3 * k + 4);
  endfunction

  // Called at a rising edge; returns at the edge that takes the item.
  task automatic send_item(input logic signed [SAMPLE_WIDTH-1:0] s, input logic eos,
                           input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    sample          <= s;
    end_of_sequence <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sender has dropped valid; wait for every median, then wait on so that an
  // item that produced none can clear the two-stage pipe.
  task automatic settle();
    do @(posedge clk); while (pending_medians != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] ws);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ws;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] ws, input int count);
    int k;
    int left;
    k = (ws == 0) ? 1 : ((int'(ws) > WINDOW_MAX) ? WINDOW_MAX : int'(ws));
    write_window(ws);
    left = 0;
    for (int i = 0; i < count; i++) begin
      if (left == 0) left = seq_len(k);
      send_item(draw_sample(), left == 1, next_gap());
      left--;
    end
    in_valid <= 1'b0;
    settle();
  endtask

  initial begin : stimulus
    int ws;
    int cnt;

    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_valid        = 1'b0;
    sample          = '0;
    end_of_sequence = 1'b0;
    hold_req        = 1'b0;
    no_gaps         = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (odd_s[i]) send_item(odd_s[i], odd_e[i], next_gap());
    in_valid <= 1'b0;
    settle();
    write_window(CFG_W'(2));
    foreach (even_s[i]) send_item(even_s[i], even_e[i], next_gap());
    in_valid <= 1'b0;
    settle();

    for (int p = 0; p < 13; p++) begin
      if (p < 10) begin
        ws  = plan_win[p];
        cnt = plan_cnt[p];
      end else begin
        ws  = $urandom_range(1, 12);
        cnt = 40;
      end
      // phase 4 keeps the sender busy while the receiver holds off
      no_gaps = (p == 4) || ($urandom_range(0, 3) == 0);
      if (p == 4) hold_req <= 1'b1;
      run_phase(CFG_W'(ws), cnt);
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/swm_readout.sv
rtl/sliding_window_median.sv
tb/swm_median_checker.sv
tb/tb_sliding_window_median.sv
